FILE: rtl/tcw_pkg.sv
// Shared constants for the text console writer: field widths, character
// codes, reset values and the register map. No dependencies.
package tcw_pkg;

    // Default screen geometry
    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    // Payload field widths
    localparam int FUNC_W     = 1;
    localparam int CHAR_W     = 8;
    localparam int IDX_W      = 11;
    localparam int ENTRY_W    = 16;
    localparam int ROW_OUT_W  = 5;
    localparam int COL_OUT_W  = 7;
    localparam int POS_OUT_W  = 11;
    localparam int COLOR_W    = 8;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_TEXT_COLOR = '0;

    // Function codes
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 1'b1;

    // Character codes and reset values
    localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'h0A;
    localparam logic [CHAR_W-1:0]  BLANK_CHAR   = 8'h20;
    localparam logic [ENTRY_W-1:0] RESET_CELL   = 16'h0720;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h07;

endpackage

FILE: rtl/tcw_screen_ram.sv
// Screen cell store: one write port and one read port, registered read data.
// Depends on tcw_pkg for the cell width.
module tcw_screen_ram #(
    parameter int DEPTH  = tcw_pkg::COLUMNS_DEF * tcw_pkg::ROWS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic                         clk,
    input  logic                         we,
    input  logic [ADDR_W-1:0]            waddr,
    input  logic [tcw_pkg::ENTRY_W-1:0]  wdata,
    input  logic                         re,
    input  logic [ADDR_W-1:0]            raddr,
    output logic [tcw_pkg::ENTRY_W-1:0]  rdata
);

    logic [tcw_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [tcw_pkg::ENTRY_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, registered and enabled by re
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/tcw_apb_regs.sv
// APB register file holding the text colour attribute.
// Depends on tcw_pkg for the register map and reset value.
module tcw_apb_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output logic [tcw_pkg::COLOR_W-1:0]      text_color
);

    logic [tcw_pkg::REG_IDX_W-1:0] reg_idx;
    logic [tcw_pkg::COLOR_W-1:0]   color_reg;
    logic [tcw_pkg::COLOR_W-1:0]   color_next;
    logic                          wr_hit;

    assign reg_idx = paddr[tcw_pkg::APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && (reg_idx == tcw_pkg::REG_TEXT_COLOR);

    // Take the low byte on a completed write transaction
    always_comb
    begin
        color_next = color_reg;
        if (wr_hit)
        begin
            color_next = pwdata[tcw_pkg::COLOR_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= tcw_pkg::RESET_COLOR;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    // Read back; unmapped addresses read zero
    always_comb
    begin
        prdata = '0;
        if (reg_idx == tcw_pkg::REG_TEXT_COLOR)
        begin
            prdata = {{(tcw_pkg::APB_DATA_W - tcw_pkg::COLOR_W){1'b0}}, color_reg};
        end
    end

    assign text_color = color_reg;

endmodule

FILE: rtl/tcw_ctrl.sv
// Sequencer for the console: clearing pass, cursor update, cell writes,
// reads and the scroll copy through the screen store. Depends on tcw_pkg.
module tcw_ctrl #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF,
    parameter int ADDR_W  = $clog2(COLUMNS * ROWS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // input channel
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]      func,
    input  logic [tcw_pkg::CHAR_W-1:0]      char_code,
    input  logic [tcw_pkg::IDX_W-1:0]       cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]     text_color,
    // result channel
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [tcw_pkg::ENTRY_W-1:0]     read_entry,
    output logic [tcw_pkg::ROW_OUT_W-1:0]   cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]   cursor_column,
    output logic [tcw_pkg::POS_OUT_W-1:0]   cursor_position,
    output logic                            scrolled,
    // screen store port
    output logic                            mem_we,
    output logic [ADDR_W-1:0]               mem_waddr,
    output logic [tcw_pkg::ENTRY_W-1:0]     mem_wdata,
    output logic                            mem_re,
    output logic [ADDR_W-1:0]               mem_raddr,
    input  logic [tcw_pkg::ENTRY_W-1:0]     mem_rdata
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int COPY_N     = CELL_COUNT - COLUMNS;
    localparam int LAST_BASE  = (ROWS - 1) * COLUMNS;
    localparam int COL_W      = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);

    typedef enum logic [4:0] {
        ST_CLEAR  = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_READ   = 5'b00100,
        ST_SCROLL = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t                       state_reg,  state_next;
    logic [CNT_W-1:0]             cnt_reg,    cnt_next;
    logic [ROW_W-1:0]             row_reg,    row_next;
    logic [COL_W-1:0]             col_reg,    col_next;
    logic [ADDR_W-1:0]            pos_reg,    pos_next;
    logic                         range_reg,  range_next;
    logic [tcw_pkg::ENTRY_W-1:0]  entry_reg,  entry_next;
    logic                         scroll_reg, scroll_next;
    logic                         ov_reg,     ov_next;
    logic [tcw_pkg::ENTRY_W-1:0]  oentry_reg, oentry_next;
    logic [ROW_W-1:0]             orow_reg,   orow_next;
    logic [COL_W-1:0]             ocol_reg,   ocol_next;
    logic [ADDR_W-1:0]            opos_reg,   opos_next;
    logic                         oscr_reg,   oscr_next;

    logic accept;
    logic last_row;
    logic last_col;
    logic in_range;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign last_row = (row_reg == ROW_W'(ROWS - 1));
    assign last_col = (col_reg == COL_W'(COLUMNS - 1));
    assign in_range = (32'(cell_index) < CELL_COUNT);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        row_next    = row_reg;
        col_next    = col_reg;
        pos_next    = pos_reg;
        range_next  = range_reg;
        entry_next  = entry_reg;
        scroll_next = scroll_reg;
        mem_we      = 1'b0;
        mem_waddr   = '0;
        mem_wdata   = '0;
        mem_re      = 1'b0;
        mem_raddr   = '0;

        unique case (state_reg)
            // Fill the store with blanks after reset
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = ADDR_W'(cnt_reg);
                mem_wdata = tcw_pkg::RESET_CELL;
                if (cnt_reg == CNT_W'(CELL_COUNT - 1))
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Take one transaction and start its work
            ST_IDLE:
            begin
                if (accept)
                begin
                    scroll_next = 1'b0;
                    entry_next  = '0;
                    if (func == tcw_pkg::FUNC_READ)
                    begin
                        range_next = in_range;
                        mem_re     = in_range;
                        mem_raddr  = ADDR_W'(cell_index);
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                        if (char_code != tcw_pkg::NEWLINE_CHAR)
                        begin
                            mem_we    = 1'b1;
                            mem_waddr = pos_reg;
                            mem_wdata = {text_color, char_code};
                        end
                        if (char_code == tcw_pkg::NEWLINE_CHAR || last_col)
                        begin
                            // move to the start of the next row, scrolling at the bottom
                            col_next = '0;
                            if (last_row)
                            begin
                                pos_next    = ADDR_W'(LAST_BASE);
                                scroll_next = 1'b1;
                                cnt_next    = '0;
                                state_next  = ST_SCROLL;
                            end
                            else
                            begin
                                row_next = row_reg + 1'b1;
                                pos_next = pos_reg + ADDR_W'(COLUMNS) - ADDR_W'(col_reg);
                            end
                        end
                        else
                        begin
                            col_next = col_reg + 1'b1;
                            pos_next = pos_reg + 1'b1;
                        end
                    end
                end
            end

            // Capture the cell read
            ST_READ:
            begin
                entry_next = range_reg ? mem_rdata : '0;
                state_next = ST_DONE;
            end

            // Copy each cell up one row, then blank the bottom row;
            // reads run one step ahead of writes and never hit the same entry
            ST_SCROLL:
            begin
                mem_re    = (cnt_reg < CNT_W'(COPY_N));
                mem_raddr = ADDR_W'(cnt_reg + CNT_W'(COLUMNS));
                mem_we    = (cnt_reg != '0);
                mem_waddr = ADDR_W'(cnt_reg - 1'b1);
                mem_wdata = (cnt_reg <= CNT_W'(COPY_N)) ? mem_rdata
                                                        : {text_color, tcw_pkg::BLANK_CHAR};
                if (cnt_reg == CNT_W'(CELL_COUNT))
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end

            // Hand the result over once the output register is free
            ST_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output register
    always_comb
    begin
        ov_next     = ov_reg;
        oentry_next = oentry_reg;
        orow_next   = orow_reg;
        ocol_next   = ocol_reg;
        opos_next   = opos_reg;
        oscr_next   = oscr_reg;
        if (state_reg == ST_DONE && (!ov_reg || out_ready))
        begin
            ov_next     = 1'b1;
            oentry_next = entry_reg;
            orow_next   = row_reg;
            ocol_next   = col_reg;
            opos_next   = pos_reg;
            oscr_next   = scroll_reg;
        end
        else if (out_ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            row_reg   <= '0;
            col_reg   <= '0;
            pos_reg   <= '0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pos_reg   <= pos_next;
            ov_reg    <= ov_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        range_reg  <= range_next;
        entry_reg  <= entry_next;
        scroll_reg <= scroll_next;
        oentry_reg <= oentry_next;
        orow_reg   <= orow_next;
        ocol_reg   <= ocol_next;
        opos_reg   <= opos_next;
        oscr_reg   <= oscr_next;
    end

    assign out_valid       = ov_reg;
    assign read_entry      = oentry_reg;
    assign cursor_row      = tcw_pkg::ROW_OUT_W'(orow_reg);
    assign cursor_column   = tcw_pkg::COL_OUT_W'(ocol_reg);
    assign cursor_position = tcw_pkg::POS_OUT_W'(opos_reg);
    assign scrolled        = oscr_reg;

endmodule

FILE: rtl/text_console_writer.sv
// Text console writer top level: screen store, sequencer and APB registers.
// Depends on tcw_pkg, tcw_screen_ram, tcw_ctrl and tcw_apb_regs.
//
// Usage: each input transaction (func, char_code, cell_index) writes one
// character at the cursor, starts a new row on a newline or reads back one
// screen cell; exactly one result transaction follows, carrying the cell
// read and the cursor after the item. The user sets text_color through the
// APB port only while the block is idle; the block does not enforce this.
// A write or newline goes from idle through the done state to the output
// register; a read also passes the read state, a scroll the scroll state.
// One item at a time is taken. A scroll moves each cell below the top row
// up one row, one cell per cycle through the store's single write port,
// then blanks the bottom row, holding the input off. Reset: a clearing pass
// writes light-grey blanks into all ROWS*COLUMNS cells, one per cycle,
// before in_ready rises; APB writes are taken during the pass.
// Stall: a result waits in the output register while out_ready is low; the
// next item is still accepted and finished, then holds until the register
// frees.
module text_console_writer #(
    parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tcw_pkg::ROWS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // APB configuration
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [tcw_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [tcw_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [tcw_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    // input channel
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [tcw_pkg::FUNC_W-1:0]       func,
    input  logic [tcw_pkg::CHAR_W-1:0]       char_code,
    input  logic [tcw_pkg::IDX_W-1:0]        cell_index,
    // result channel
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcw_pkg::ENTRY_W-1:0]      read_entry,
    output logic [tcw_pkg::ROW_OUT_W-1:0]    cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]    cursor_column,
    output logic [tcw_pkg::POS_OUT_W-1:0]    cursor_position,
    output logic                             scrolled
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);

    logic [tcw_pkg::COLOR_W-1:0] text_color;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_waddr;
    logic [tcw_pkg::ENTRY_W-1:0] mem_wdata;
    logic                        mem_re;
    logic [ADDR_W-1:0]           mem_raddr;
    logic [tcw_pkg::ENTRY_W-1:0] mem_rdata;

    tcw_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .text_color (text_color)
    );

    tcw_screen_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .func            (func),
        .char_code       (char_code),
        .cell_index      (cell_index),
        .text_color      (text_color),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_entry      (read_entry),
        .cursor_row      (cursor_row),
        .cursor_column   (cursor_column),
        .cursor_position (cursor_position),
        .scrolled        (scrolled),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_re          (mem_re),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

`ifndef ASSERT_OFF
    // Never read and write the same cell in one cycle
    a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_waddr != mem_raddr))
        else $error("screen store read and write hit the same cell");

    // One item at a time: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input accepted while an item is in flight");

    // A scroll always leaves the cursor at column zero
    a_scroll_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && scrolled) |-> (cursor_column == '0))
        else $error("scroll result with nonzero cursor column");
`endif

endmodule
